>>> rtl/bpq_pkg.sv
package bpq_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned PriW  = 16;
  localparam int unsigned FillW = 4;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  typedef struct packed {
    logic                   valid;
    logic signed [PriW-1:0] pri;
    logic        [ValW-1:0] val;
  } entry_t;

  // shift command broadcast to every cell; at most one of insert and remove is set per cycle
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

>>> rtl/bounded_priority_queue_core.sv
// result word: registered, and valid in the cycle after its input word is accepted
// throughput: one word per cycle while results are taken; each cell of the sorted row updates in the same cycle
// a held result only stalls the input while the output register is full and not taken
// reset: asynchronous active low, empties the queue and drops any pending result;
// entry payload is not cleared
module bounded_priority_queue_core #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // item_value[31:0], item_priority[47:32]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_value[31:0], out_priority[47:32], fill_level[51:48]
  output logic [1:0]  m_axis_tuser   // status
);
  import bpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t    cell_q   [DEPTH];
  logic      take     [DEPTH];
  logic      left_take[DEPTH];
  entry_t    left_in  [DEPTH];
  entry_t    right_in [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  entry_t    new_entry;
  cell_ctl_t ctl;

  logic            accept, full, enq_ok, deq_ok;
  logic [CntW-1:0] count_q, count_d;

  logic                   out_valid_q;
  logic        [ValW-1:0] out_val_q, out_val_d;
  logic signed [PriW-1:0] out_pri_q, out_pri_d;
  status_e                out_st_q, out_st_d;
  logic       [FillW-1:0] out_fill_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(DEPTH));
  assign enq_ok        = accept && (s_axis_tuser == ACT_ENQUEUE) && !full;
  assign deq_ok        = accept && (s_axis_tuser == ACT_DEQUEUE) && cell_q[0].valid;

  assign ctl       = '{insert: enq_ok, remove: deq_ok};
  assign new_entry = '{valid: 1'b1, pri: s_axis_tdata[47:32], val: s_axis_tdata[31:0]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_take[i] = 1'b0;
      assign left_in[i]   = new_entry;
    end else begin : g_body
      assign left_take[i] = take[i-1];
      assign left_in[i]   = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in[i] = '{valid: 1'b0, pri: '0, val: '0};
    end else begin : g_inner
      assign right_in[i] = cell_q[i+1];
    end
    assign valid_vec[i] = cell_q[i].valid;

    bpq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_i      (new_entry),
      .left_i     (left_in[i]),
      .left_take_i(left_take[i]),
      .right_i    (right_in[i]),
      .entry_o    (cell_q[i]),
      .take_o     (take[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_val_d = '0;
    out_pri_d = '0;
    if (s_axis_tuser == ACT_ENQUEUE) begin
      out_st_d = full ? ST_FULL : ST_ENQUEUED;
    end else if (cell_q[0].valid) begin
      out_st_d  = ST_DEQUEUED;
      out_val_d = cell_q[0].val;
      out_pri_d = cell_q[0].pri;
    end else begin
      out_st_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_val_q  <= out_val_d;
      out_pri_q  <= out_pri_d;
      out_st_q   <= out_st_d;
      out_fill_q <= FillW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_fill_q, out_pri_q, out_val_q};
  assign m_axis_tuser  = out_st_q;

  // occupied cells always form a prefix of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in occupied cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("fill count out of step with cells");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

endmodule

>>> rtl/bpq_cell.sv
module bpq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpq_pkg::cell_ctl_t ctl_i,
  input  bpq_pkg::entry_t    new_i,
  input  bpq_pkg::entry_t    left_i,
  input  logic               left_take_i,
  input  bpq_pkg::entry_t    right_i,
  output bpq_pkg::entry_t    entry_o,
  output logic               take_o
);
  import bpq_pkg::*;

  logic                   valid_q, valid_d;
  logic signed [PriW-1:0] pri_q, pri_d;
  logic        [ValW-1:0] val_q, val_d;

  // new word lands here or further up the row; ties stay behind older entries
  assign take_o = !valid_q || (new_i.pri > pri_q);

  always_comb begin
    valid_d = valid_q;
    pri_d   = pri_q;
    val_d   = val_q;
    if (ctl_i.remove) begin
      valid_d = right_i.valid;
      pri_d   = right_i.pri;
      val_d   = right_i.val;
    end else if (ctl_i.insert && take_o) begin
      if (left_take_i) begin
        valid_d = left_i.valid;
        pri_d   = left_i.pri;
        val_d   = left_i.val;
      end else begin
        valid_d = 1'b1;
        pri_d   = new_i.pri;
        val_d   = new_i.val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    val_q <= val_d;
  end

  assign entry_o = '{valid: valid_q, pri: pri_q, val: val_q};

endmodule

>>> bench/bounded_priority_queue_core_tb.sv
module bounded_priority_queue_core_tb;
  import bpq_pkg::*;

  localparam int unsigned DEPTH      = 8;
  localparam int unsigned HALF_CYCLE = 6;
  localparam int unsigned STALL_CAP  = 4000;

  typedef struct {
    action_e                act;
    logic        [ValW-1:0] val;
    logic signed [PriW-1:0] pri;
  } request_t;

  typedef struct {
    logic        [ValW-1:0]  val;
    logic signed [PriW-1:0]  pri;
    status_e                 st;
    logic        [FillW-1:0] fill;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  request_t pending_q[$];
  reply_t   reply_q[$];
  request_t on_bus;
  bit       taken = 1'b0;
  int       send_idle = 0;
  int       recv_stall = 0;
  int       errors = 0;
  int       quiet_cycles = 0;

  // shadow of the queue contents in insertion order
  logic        [ValW-1:0] shadow_val[DEPTH];
  logic signed [PriW-1:0] shadow_pri[DEPTH];
  int                     shadow_count = 0;

  bounded_priority_queue_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(HALF_CYCLE) clk_i = ~clk_i;

  function automatic reply_t serve_request(request_t req);
    reply_t r;
    int     best;
    r.val  = '0;
    r.pri  = '0;
    if (req.act == ACT_ENQUEUE) begin
      if (shadow_count >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        shadow_val[shadow_count] = req.val;
        shadow_pri[shadow_count] = req.pri;
        shadow_count++;
        r.st = ST_ENQUEUED;
      end
    end else if (shadow_count == 0) begin
      r.st = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_pri[i] > shadow_pri[best]) best = i;
      end
      r.val = shadow_val[best];
      r.pri = shadow_pri[best];
      for (int i = best; i + 1 < shadow_count; i++) begin
        shadow_val[i] = shadow_val[i+1];
        shadow_pri[i] = shadow_pri[i+1];
      end
      shadow_count--;
      r.st = ST_DEQUEUED;
    end
    r.fill = FillW'(shadow_count);
    return r;
  endfunction

  task automatic add_request(action_e act, logic [ValW-1:0] val, logic [PriW-1:0] pri);
    request_t req;
    req.act = act;
    req.val = val;
    req.pri = pri;
    pending_q.push_back(req);
  endtask

  function automatic logic [PriW-1:0] pick_priority();
    logic [PriW-1:0] p;
    case ($urandom_range(3))
      0: p = PriW'($signed($urandom_range(4)) - 2);
      1: p = $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: p = PriW'($urandom);
    endcase
    return p;
  endfunction

  task automatic add_random_run(int count);
    int enq_pct;
    enq_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) begin
        case ($urandom_range(3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 90;
        endcase
      end
      add_request(($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE,
                  $urandom, pick_priority());
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
    if (rst_ni && (!s_axis_tvalid || taken)) begin
      taken = 1'b0;
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        on_bus = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {on_bus.pri, on_bus.val};
        s_axis_tuser  <= on_bus.act;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    reply_t exp_r;
    bit     moved;
    moved = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready && !taken) begin
      reply_q.push_back(serve_request(on_bus));
      taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      if (reply_q.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_r = reply_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.val) begin
          $error("out_value expected %h actual %h", exp_r.val, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[47:32] !== exp_r.pri) begin
          $error("out_priority expected %h actual %h", exp_r.pri, m_axis_tdata[47:32]);
          errors++;
        end
        if (m_axis_tuser !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[51:48] !== exp_r.fill) begin
          $error("fill_level expected %0d actual %0d", exp_r.fill, m_axis_tdata[51:48]);
          errors++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty, extremes, ties, full and back to empty
    add_request(ACT_DEQUEUE, 32'hffffffff, 16'hffff);
    add_request(ACT_ENQUEUE, 32'h80000000, 16'h8000);
    add_request(ACT_ENQUEUE, 32'h7fffffff, 16'h7fff);
    add_request(ACT_ENQUEUE, 32'h00000001, 16'd5);
    add_request(ACT_ENQUEUE, 32'h00000002, 16'd5);
    add_request(ACT_ENQUEUE, 32'h00000000, 16'h0000);
    add_request(ACT_ENQUEUE, 32'hffffffff, 16'hffff);
    add_request(ACT_ENQUEUE, 32'h00000003, 16'h7fff);
    add_request(ACT_ENQUEUE, 32'h00000004, 16'd5);
    add_request(ACT_ENQUEUE, 32'h00000005, 16'd1);
    for (int i = 0; i < DEPTH + 1; i++) begin
      add_request(ACT_DEQUEUE, 32'h0, 16'h0);
    end
    add_request(ACT_ENQUEUE, 32'h00000009, 16'h8000);
    add_request(ACT_DEQUEUE, 32'h12345678, 16'h4321);

    add_random_run(90);
    drain();

    send_idle  = 80;
    recv_stall = 0;
    add_random_run(112);
    drain();

    send_idle  = 0;
    recv_stall = 80;
    add_random_run(112);
    drain();

    send_idle  = 17;
    recv_stall = 17;
    add_random_run(112);
    drain();

    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
